[sv/fbfla_pkg.sv]
`timescale 1ns / 1ps

package fbfla_pkg;

    // Fixed field widths of the streaming and configuration channels.
    localparam int ADDR_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int FREE_W      = 11;
    localparam int SH_W        = 5;
    localparam int CNT_CFG_W   = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // Block size limits (log2 of bytes) and the reset block count.
    localparam logic [SH_W-1:0] SH_MIN   = 5'd3;
    localparam logic [SH_W-1:0] SH_MAX   = 5'd16;
    localparam logic [SH_W-1:0] SH_RESET = 5'd4;
    localparam int CNT_RESET = 1024;

    // The pool base is always 16-byte aligned.
    localparam logic [ADDR_W-1:0] BASE_MASK = 32'hFFFF_FFF0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BASE  = 2'd0,
        REG_BLOCK_LOG2 = 2'd1,
        REG_BLOCK_CNT  = 2'd2,
        REG_UNUSED     = 2'd3
    } t_cfg_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_FILL,
        S_INIT_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic    accept;
        logic    fill_write;
        logic    alloc_read;
        logic    alloc_commit;
        logic    free_commit;
        logic    init_commit;
        logic    emit;
        logic    emit_grant;
        t_status emit_status;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic free_ok;
        logic fill_last;
        logic slot_free;
    } t_dp_status;

endpackage

[sv/fbfla_ctrl.sv]
`timescale 1ns / 1ps

module fbfla_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fbfla_pkg::t_dp_status i_stat,
    output fbfla_pkg::t_dp_cmd    o_cmd
);

    fbfla_pkg::t_state r_state;
    fbfla_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbfla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        o_cmd.emit_status = fbfla_pkg::ST_OK;
        unique case (r_state)
            fbfla_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = fbfla_pkg::S_DISPATCH;
                end
            end
            fbfla_pkg::S_DISPATCH: begin
                unique case (i_stat.cmd)
                    fbfla_pkg::CMD_INIT: begin
                        n_state = fbfla_pkg::S_FILL;
                    end
                    fbfla_pkg::CMD_ALLOC: begin
                        if (!i_stat.empty) begin
                            o_cmd.alloc_read = 1'b1;
                            n_state          = fbfla_pkg::S_POP;
                        end else if (i_stat.slot_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fbfla_pkg::ST_EMPTY;
                            n_state           = fbfla_pkg::S_IDLE;
                        end
                    end
                    fbfla_pkg::CMD_FREE: begin
                        if (i_stat.slot_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = fbfla_pkg::S_IDLE;
                            if (i_stat.free_ok) begin
                                o_cmd.free_commit = 1'b1;
                            end else begin
                                o_cmd.emit_status = fbfla_pkg::ST_BAD_ADDR;
                            end
                        end
                    end
                    fbfla_pkg::CMD_NOP: begin
                        if (i_stat.slot_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = fbfla_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = fbfla_pkg::S_IDLE;
                    end
                endcase
            end
            fbfla_pkg::S_POP: begin
                if (i_stat.slot_free) begin
                    o_cmd.alloc_commit = 1'b1;
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_grant   = 1'b1;
                    n_state            = fbfla_pkg::S_IDLE;
                end
            end
            fbfla_pkg::S_FILL: begin
                o_cmd.fill_write = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = fbfla_pkg::S_INIT_DONE;
                end
            end
            fbfla_pkg::S_INIT_DONE: begin
                if (i_stat.slot_free) begin
                    o_cmd.init_commit = 1'b1;
                    o_cmd.emit        = 1'b1;
                    n_state           = fbfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbfla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/fbfla_dp.sv]
`timescale 1ns / 1ps

module fbfla_dp #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_write,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbfla_pkg::ADDR_W-1:0]         i_cfg_data,
    input  logic [fbfla_pkg::CMD_W-1:0]          i_in_cmd,
    input  logic [fbfla_pkg::ADDR_W-1:0]         i_in_addr,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [fbfla_pkg::ADDR_W-1:0]         o_out_grant,
    output fbfla_pkg::t_status                   o_out_status,
    output logic [fbfla_pkg::FREE_W-1:0]         o_out_free,
    input  fbfla_pkg::t_dp_cmd                   i_cmd,
    output fbfla_pkg::t_dp_status                o_stat
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int AW    = fbfla_pkg::ADDR_W;
    localparam int FW    = fbfla_pkg::FREE_W;
    localparam int RST_COUNT = (MAX_BLOCKS < fbfla_pkg::CNT_RESET) ?
                               MAX_BLOCKS : fbfla_pkg::CNT_RESET;
    localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_BLOCKS);

    // Effective configuration, already clamped on write.
    logic [AW-1:0]                   r_base;
    logic [fbfla_pkg::SH_W-1:0]      r_sh;
    logic [CNT_W-1:0]                r_count;

    // Free chain state.
    logic [CNT_W-1:0]                r_head;
    logic [CNT_W-1:0]                r_total;
    logic [CNT_W-1:0]                n_head;
    logic [CNT_W-1:0]                n_total;

    // Item under work.
    fbfla_pkg::t_cmd                 r_cmd;
    logic [AW-1:0]                   r_off;
    logic [IDX_W-1:0]                r_sweep;
    logic [CNT_W-1:0]                r_link;
    logic [AW-1:0]                   r_grant;

    // Result register.
    logic                            r_out_valid;
    logic [AW-1:0]                   r_out_grant;
    fbfla_pkg::t_status              r_out_status;
    logic [FW-1:0]                   r_out_free;

    // Link memory.
    logic [CNT_W-1:0]                mem [MAX_BLOCKS];
    logic                            w_we;
    logic [IDX_W-1:0]                w_waddr;
    logic [CNT_W-1:0]                w_wdata;

    logic [AW-1:0]                   w_idx;
    logic                            w_aligned;
    logic                            w_free_ok;
    logic                            w_fill_last;
    logic [CNT_W-1:0]                w_sweep_next;
    logic [CNT_W-1:0]                w_pop_next;
    logic [CNT_W+FW-1:0]             w_free_ext;
    logic [31:0]                     w_cfg_cnt;
    logic [fbfla_pkg::SH_W-1:0]      w_cfg_sh;

    // Configuration writes, clamped to the legal ranges.
    assign w_cfg_cnt = {{(32 - fbfla_pkg::CNT_CFG_W){1'b0}},
                        i_cfg_data[fbfla_pkg::CNT_CFG_W-1:0]};
    assign w_cfg_sh  = i_cfg_data[fbfla_pkg::SH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_sh    <= fbfla_pkg::SH_RESET;
            r_count <= CNT_W'(RST_COUNT);
        end else if (i_cfg_write) begin
            unique case (fbfla_pkg::t_cfg_reg'(i_cfg_index))
                fbfla_pkg::REG_POOL_BASE: begin
                    r_base <= i_cfg_data & fbfla_pkg::BASE_MASK;
                end
                fbfla_pkg::REG_BLOCK_LOG2: begin
                    if (w_cfg_sh < fbfla_pkg::SH_MIN) begin
                        r_sh <= fbfla_pkg::SH_MIN;
                    end else if (w_cfg_sh > fbfla_pkg::SH_MAX) begin
                        r_sh <= fbfla_pkg::SH_MAX;
                    end else begin
                        r_sh <= w_cfg_sh;
                    end
                end
                fbfla_pkg::REG_BLOCK_CNT: begin
                    if (w_cfg_cnt == 32'd0) begin
                        r_count <= CNT_W'(1);
                    end else if (w_cfg_cnt > 32'(MAX_BLOCKS)) begin
                        r_count <= NULL_LINK;
                    end else begin
                        r_count <= w_cfg_cnt[CNT_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Free address decode: offset from base, block index and alignment.
    assign w_idx     = r_off >> r_sh;
    assign w_aligned = (r_off & ~({AW{1'b1}} << r_sh)) == '0;
    assign w_free_ok = w_aligned && (w_idx < AW'(r_count)) && (r_total < r_count);

    // Init sweep position and the link that the sweep writes.
    assign w_sweep_next = CNT_W'(r_sweep) + CNT_W'(1);
    assign w_fill_last  = (w_sweep_next == r_count);
    assign w_pop_next   = (r_link >= NULL_LINK) ? NULL_LINK : r_link;

    // Memory write port: init sweep or free push.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_sweep;
        w_wdata = w_fill_last ? NULL_LINK : w_sweep_next;
        if (i_cmd.fill_write) begin
            w_we = 1'b1;
        end else if (i_cmd.free_commit) begin
            w_we    = 1'b1;
            w_waddr = w_idx[IDX_W-1:0];
            w_wdata = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    // Registered read of the head's link, with the granted address beside it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_read) begin
            r_link  <= mem[r_head[IDX_W-1:0]];
            r_grant <= r_base + (AW'(r_head) << r_sh);
        end
    end

    // Item capture and sweep counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= fbfla_pkg::t_cmd'(i_in_cmd);
            r_off   <= i_in_addr - r_base;
            r_sweep <= '0;
        end else if (i_cmd.fill_write) begin
            r_sweep <= w_sweep_next[IDX_W-1:0];
        end
    end

    // Head and free count updates.
    always_comb begin
        n_head  = r_head;
        n_total = r_total;
        priority if (i_cmd.init_commit) begin
            n_head  = '0;
            n_total = r_count;
        end else if (i_cmd.alloc_commit) begin
            n_head  = w_pop_next;
            n_total = r_total - CNT_W'(1);
        end else if (i_cmd.free_commit) begin
            n_head  = w_idx[CNT_W-1:0];
            n_total = r_total + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NULL_LINK;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_total <= n_total;
        end
    end

    // Result register; it is reloaded once the consumer has taken the last item.
    assign w_free_ext = {{FW{1'b0}}, n_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_grant  <= i_cmd.emit_grant ? r_grant : '0;
            r_out_status <= i_cmd.emit_status;
            r_out_free   <= w_free_ext[FW-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_grant  = r_out_grant;
    assign o_out_status = r_out_status;
    assign o_out_free   = r_out_free;

    // Status toward the controller.
    assign o_stat.cmd       = r_cmd;
    assign o_stat.empty     = (r_total == '0) || (r_head >= NULL_LINK);
    assign o_stat.free_ok   = w_free_ok;
    assign o_stat.fill_last = w_fill_last;
    assign o_stat.slot_free = !r_out_valid || i_out_ready;

endmodule

[sv/fixed_block_free_list_allocator_unit.sv]
`timescale 1ns / 1ps

// Fixed-size block pool allocator with a LIFO free list held in a link memory.
// Input stream: tuser carries the command (init, allocate, free, no-op), tdata
// the byte address of a block to free. Output stream: one result item per
// command with the granted address, the free block count and a status code.
// The configuration channel writes pool base, block size and block count; it
// is always ready, and it must be written only while no command is in progress,
// which the user must ensure: the block itself does not enforce it. After input
// accept, free, no-op and an allocate on an empty pool go from dispatch to the
// result register; a granted allocate passes through pop as well (the registered
// link memory read sits between head and pop), and init writes one link per cycle
// in fill, then ends in init done. Items are taken one at a time: the next item
// is accepted only once the result of the last one has been written. A result
// sits in an output register, so the next item is accepted while it waits; a
// stalled receiver only holds the next result from being written, and the unit
// then waits with its state untouched. After reset the pool is empty (head null,
// free count zero) and the link memory holds nothing useful until an init or a
// free writes it.
module fixed_block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write channel.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fbfla_pkg::ADDR_W-1:0]           i_cfg_data,
    // Command stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [fbfla_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [31:0] block_address
    input  logic [fbfla_pkg::CMD_W-1:0]            s_axis_tuser,  // [1:0] command
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [fbfla_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [31:0] granted_address,
                                                                  // [42:32] free_blocks
    output logic [fbfla_pkg::STATUS_W-1:0]         m_axis_tuser   // [1:0] status
);

    localparam int PAD_W = fbfla_pkg::OUT_TDATA_W - fbfla_pkg::ADDR_W - fbfla_pkg::FREE_W;

    fbfla_pkg::t_dp_cmd                 w_cmd;
    fbfla_pkg::t_dp_status              w_stat;
    logic [fbfla_pkg::ADDR_W-1:0]       w_grant;
    fbfla_pkg::t_status                 w_status;
    logic [fbfla_pkg::FREE_W-1:0]       w_free;

    assign o_cfg_ready = 1'b1;

    // Command sequencing.
    fbfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Configuration, chain state, link memory and result register.
    fbfla_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_write  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_cmd     (s_axis_tuser),
        .i_in_addr    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_grant  (w_grant),
        .o_out_status (w_status),
        .o_out_free   (w_free),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

    // Result packing.
    assign m_axis_tdata = {{PAD_W{1'b0}}, w_free, w_grant};
    assign m_axis_tuser = w_status;

endmodule

[dv/fbfla_reply_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration, command and result channels of the block pool
// allocator, tracks the pool on its own and compares every result item.
module fbfla_reply_checker
    import fbfla_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ADDR_W-1:0]      i_cfg_data,
    input  logic                   i_cmd_valid,
    input  logic                   i_cmd_ready,
    input  logic [IN_TDATA_W-1:0]  i_cmd_data,
    input  logic [CMD_W-1:0]       i_cmd_code,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [OUT_TDATA_W-1:0] i_res_data,
    input  logic [STATUS_W-1:0]    i_res_status,
    output int                     o_replies_owed,
    output int                     o_mismatch_cnt
);

    localparam int POOL_MAX = 1024;
    localparam logic [FREE_W-1:0] NULL_LINK = 11'd1024;

    typedef struct {
        logic [ADDR_W-1:0] granted;
        t_status           status;
        logic [FREE_W-1:0] free_cnt;
    } pool_reply_t;

    // Replies the pool owes, oldest first.
    pool_reply_t replies_owed[$];
    int          mismatch_cnt = 0;

    // Shadow of the configuration registers.
    logic [ADDR_W-1:0]    pool_base;
    logic [SH_W-1:0]      size_log2;
    logic [CNT_CFG_W-1:0] block_cnt;

    // Shadow of the free chain.
    logic [FREE_W-1:0] link_mem [POOL_MAX];
    logic [FREE_W-1:0] head_idx;
    logic [FREE_W-1:0] free_cnt;

    // Apply one command to the shadow pool and queue the reply it owes.
    task automatic advance_pool(input t_cmd cmd, input logic [ADDR_W-1:0] addr);
        pool_reply_t       reply;
        logic [SH_W-1:0]   sh;
        logic [FREE_W-1:0] cnt;
        logic [ADDR_W-1:0] base_eff;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] blk;
        reply.granted = '0;
        reply.status  = ST_OK;
        sh = (size_log2 < SH_MIN) ? SH_MIN : (size_log2 > SH_MAX) ? SH_MAX : size_log2;
        if (block_cnt == 0) begin
            cnt = 11'd1;
        end else if (block_cnt > POOL_MAX) begin
            cnt = NULL_LINK;
        end else begin
            cnt = block_cnt;
        end
        base_eff = pool_base & BASE_MASK;
        case (cmd)
            CMD_INIT: begin
                for (int i = 0; i < cnt; i++) begin
                    link_mem[i] = (i + 1 < cnt) ? FREE_W'(i + 1) : NULL_LINK;
                end
                head_idx = '0;
                free_cnt = cnt;
            end
            CMD_ALLOC: begin
                if (free_cnt == 0 || head_idx >= NULL_LINK) begin
                    reply.status = ST_EMPTY;
                end else begin
                    blk = ADDR_W'(head_idx);
                    reply.granted = base_eff + (blk << sh);
                    head_idx = (link_mem[head_idx] > NULL_LINK) ? NULL_LINK
                                                                : link_mem[head_idx];
                    free_cnt = free_cnt - 1'b1;
                end
            end
            CMD_FREE: begin
                // Offset wraps modulo the address width, so an address below
                // the base decodes as a huge index.
                offset = addr - base_eff;
                blk    = offset >> sh;
                if ((offset & ((32'd1 << sh) - 1)) != 0 || blk >= cnt || free_cnt >= cnt) begin
                    reply.status = ST_BAD_ADDR;
                end else begin
                    link_mem[blk[9:0]] = head_idx;
                    head_idx = blk[FREE_W-1:0];
                    free_cnt = free_cnt + 1'b1;
                end
            end
            default: ;
        endcase
        reply.free_cnt = free_cnt;
        replies_owed.push_back(reply);
    endtask

    always @(posedge i_clk) begin
        pool_reply_t want;
        if (!i_rst_n) begin
            pool_base = '0;
            size_log2 = SH_RESET;
            block_cnt = CNT_CFG_W'(CNT_RESET);
            head_idx  = NULL_LINK;
            free_cnt  = '0;
            replies_owed.delete();
        end else begin
            // Register writes are shadowed as soon as they are taken; the bench writes only while the pool is idle.
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_POOL_BASE:  pool_base = i_cfg_data;
                    REG_BLOCK_LOG2: size_log2 = i_cfg_data[SH_W-1:0];
                    REG_BLOCK_CNT:  block_cnt = i_cfg_data[CNT_CFG_W-1:0];
                    default: ;
                endcase
            end

            // Retire a result item against the oldest owed reply.
            if (i_res_valid && i_res_ready) begin
                if (replies_owed.size() == 0) begin
                    $error("result item with no command outstanding");
                    mismatch_cnt++;
                end else begin
                    want = replies_owed.pop_front();
                    if (i_res_data[31:0] !== want.granted) begin
                        $error("granted_address: expected 0x%08h, actual 0x%08h",
                               want.granted, i_res_data[31:0]);
                        mismatch_cnt++;
                    end
                    if (i_res_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_res_status);
                        mismatch_cnt++;
                    end
                    if (i_res_data[42:32] !== want.free_cnt) begin
                        $error("free_blocks: expected %0d, actual %0d",
                               want.free_cnt, i_res_data[42:32]);
                        mismatch_cnt++;
                    end
                end
            end

            if (i_cmd_valid && i_cmd_ready) begin
                advance_pool(t_cmd'(i_cmd_code), i_cmd_data[ADDR_W-1:0]);
            end
        end
        o_replies_owed <= replies_owed.size();
        o_mismatch_cnt <= mismatch_cnt;
    end

endmodule

[dv/tb_fixed_block_free_list_allocator_unit.sv]
`timescale 1ns / 1ps

// Drives commands and pool settings into the allocator and gives the verdict.
module tb_fixed_block_free_list_allocator_unit;
    import fbfla_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 75;
    localparam int PHASE_CNT   = 8;
    localparam int POOL_MAX    = 1024;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = REG_POOL_BASE;
    logic [ADDR_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]       s_axis_tuser  = CMD_NOP;
    logic                   m_axis_tready = 1'b0;
    logic                   o_cfg_ready;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    int          replies_owed;
    int          mismatch_cnt;
    int          send_idle = 24;
    int          recv_idle = 48;
    int unsigned cycle_cnt = 0;

    // Register values as last written, used to aim frees at real blocks.
    logic [ADDR_W-1:0]    cur_base = '0;
    logic [SH_W-1:0]      cur_log2 = SH_RESET;
    logic [CNT_CFG_W-1:0] cur_cnt  = CNT_CFG_W'(CNT_RESET);

    fixed_block_free_list_allocator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fbfla_reply_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (s_axis_tvalid),
        .i_cmd_ready    (s_axis_tready),
        .i_cmd_data     (s_axis_tdata),
        .i_cmd_code     (s_axis_tuser),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .i_res_status   (m_axis_tuser),
        .o_replies_owed (replies_owed),
        .o_mismatch_cnt (mismatch_cnt)
    );

    always #5 i_clk = ~i_clk;

    // The result side stalls at random at the current rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_fixed_block_free_list_allocator_unit failed");
            $finish;
        end
    end

    function automatic int unsigned pool_blocks();
        if (cur_cnt == 0) return 1;
        if (cur_cnt > POOL_MAX) return POOL_MAX;
        return 32'(cur_cnt);
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx);
        logic [SH_W-1:0] sh;
        sh = (cur_log2 < SH_MIN) ? SH_MIN : (cur_log2 > SH_MAX) ? SH_MAX : cur_log2;
        return (cur_base & BASE_MASK) + (idx << sh);
    endfunction

    // Present one command item, after an optional random gap, and wait for it
    // to be taken. Valid stays high afterward so items can go back to back.
    task automatic send_item(input t_cmd cmd, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every owed result item has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_owed != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [ADDR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_POOL_BASE:  cur_base = value;
            REG_BLOCK_LOG2: cur_log2 = value[SH_W-1:0];
            REG_BLOCK_CNT:  cur_cnt  = value[CNT_CFG_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        logic [ADDR_W-1:0]    junk;
        logic [ADDR_W-1:0]    slot;
        logic [ADDR_W-1:0]    new_base;
        logic [SH_W-1:0]      new_log2;
        logic [CNT_CFG_W-1:0] new_cnt;
        int                   pick;
        int                   init_pct;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty pool, frees before any init, bad addresses.
        send_item(CMD_ALLOC, 32'hFFFF_FFFF);
        send_item(CMD_FREE, block_addr(5));
        send_item(CMD_ALLOC, 32'h0000_0000);
        send_item(CMD_ALLOC, $urandom());
        send_item(CMD_NOP, 32'hFFFF_FFFF);
        send_item(CMD_FREE, block_addr(5) + 32'd8);
        send_item(CMD_FREE, block_addr(POOL_MAX));
        send_item(CMD_FREE, 32'hFFFF_FFFF);
        send_item(CMD_FREE, block_addr(0));

        // Values below and above range clamp: one 8-byte block at the top.
        wait_idle();
        write_reg(REG_POOL_BASE, 32'hFFFF_FFFF);
        write_reg(REG_BLOCK_LOG2, 32'hFFFF_FFE0);
        write_reg(REG_BLOCK_CNT, 32'hFFFF_F800);
        write_reg(REG_UNUSED, $urandom());
        send_item(CMD_INIT, $urandom());
        send_item(CMD_ALLOC, $urandom());
        send_item(CMD_ALLOC, $urandom());
        send_item(CMD_FREE, 32'hFFFF_FFF0);
        send_item(CMD_FREE, 32'hFFFF_FFF0);
        send_item(CMD_FREE, 32'h0000_0000);

        // Reconfigure without init, then the full 1024 blocks of 64 KiB.
        wait_idle();
        write_reg(REG_POOL_BASE, 32'h1234_5678);
        write_reg(REG_BLOCK_LOG2, 32'h0000_001F);
        write_reg(REG_BLOCK_CNT, 32'h0000_07FF);
        send_item(CMD_ALLOC, $urandom());
        send_item(CMD_FREE, block_addr(POOL_MAX - 1));
        send_item(CMD_INIT, $urandom());
        send_item(CMD_ALLOC, $urandom());
        send_item(CMD_ALLOC, $urandom());
        send_item(CMD_FREE, block_addr(POOL_MAX - 1));
        send_item(CMD_FREE, block_addr(POOL_MAX - 1) + 32'd1);
        send_item(CMD_FREE, block_addr(0) - (32'd1 << 16));
        send_item(CMD_NOP, 32'h0000_0000);

        // Random traffic over a range of pool settings.
        for (int phase = 0; phase < PHASE_CNT; phase++) begin
            wait_idle();
            if (phase == 3) begin
                send_idle = 48;
                recv_idle <= 24;
            end else if (phase == 6) begin
                send_idle = 0;
                recv_idle <= 0;
            end
            case (phase)
                0: begin
                    new_base = 32'h0000_0000;
                    new_log2 = 5'd3;
                    new_cnt  = 11'd4;
                end
                1: begin
                    new_base = 32'h8000_0007;
                    new_log2 = 5'd4;
                    new_cnt  = 11'd8;
                end
                2: begin
                    new_base = 32'hFFFF_FFFF;
                    new_log2 = 5'd16;
                    new_cnt  = 11'd1024;
                end
                3: begin
                    new_base = $urandom();
                    new_log2 = SH_W'($urandom_range(3, 16));
                    new_cnt  = 11'd0;
                end
                4: begin
                    new_base = $urandom();
                    new_log2 = 5'd2;
                    new_cnt  = 11'd16;
                end
                5: begin
                    new_base = $urandom();
                    new_log2 = 5'd9;
                    new_cnt  = 11'd2047;
                end
                6: begin
                    new_base = 32'h0000_1000;
                    new_log2 = 5'd31;
                    new_cnt  = 11'd3;
                end
                default: begin
                    new_base = $urandom();
                    new_log2 = SH_W'($urandom_range(0, 31));
                    new_cnt  = CNT_CFG_W'($urandom_range(1, 12));
                end
            endcase
            junk = $urandom();
            write_reg(REG_POOL_BASE, new_base);
            write_reg(REG_BLOCK_LOG2, {junk[31:5], new_log2});
            write_reg(REG_BLOCK_CNT, {junk[31:11], new_cnt});

            // Large pools take a long init walk, so init is rarer there.
            init_pct = (pool_blocks() > 64) ? 2 : 6;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                junk = $urandom();
                slot = block_addr($urandom_range(pool_blocks() - 1));
                if (pick < init_pct) begin
                    send_item(CMD_INIT, junk);
                end else if (pick < 45) begin
                    send_item(CMD_ALLOC, junk);
                end else if (pick < 82) begin
                    send_item(CMD_FREE, slot);
                end else if (pick < 92) begin
                    send_item(CMD_FREE, slot ^ (32'd1 << $urandom_range(31)));
                end else if (pick < 97) begin
                    send_item(CMD_FREE, junk);
                end else begin
                    send_item(CMD_NOP, junk);
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb_fixed_block_free_list_allocator_unit passed");
        end else begin
            $display("tb_fixed_block_free_list_allocator_unit failed");
        end
        $finish;
    end

endmodule
